### design/mseq_pkg.sv
package mseq_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int DLY_BITS    = 48;
    localparam int CH_BITS     = 5;
    localparam int IDX_BITS    = 4;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + 3;

    localparam int WORDS_PER_CH = 12;
    localparam int DLY_PER_CH   = 4;

    // command codes
    localparam logic CMD_RENDER = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // coefficient word layout within one channel
    localparam logic [IDX_BITS-1:0] IDX_PAN     = 4'd0;
    localparam logic [IDX_BITS-1:0] IDX_OUTGAIN = 4'd1;
    localparam logic [IDX_BITS-1:0] IDX_HI_B0   = 4'd2;
    localparam logic [IDX_BITS-1:0] IDX_HI_B1   = 4'd3;
    localparam logic [IDX_BITS-1:0] IDX_HI_B2   = 4'd4;
    localparam logic [IDX_BITS-1:0] IDX_HI_A1   = 4'd5;
    localparam logic [IDX_BITS-1:0] IDX_HI_A2   = 4'd6;
    localparam logic [IDX_BITS-1:0] IDX_LO_B0   = 4'd7;
    localparam logic [IDX_BITS-1:0] IDX_LO_B1   = 4'd8;
    localparam logic [IDX_BITS-1:0] IDX_LO_B2   = 4'd9;
    localparam logic [IDX_BITS-1:0] IDX_LO_A1   = 4'd10;
    localparam logic [IDX_BITS-1:0] IDX_LO_A2   = 4'd11;
    localparam logic [IDX_BITS-1:0] IDX_BYPASS  = 4'd12;

    // delay word layout within one channel
    localparam logic [1:0] DLY_HI_Z1 = 2'd0;
    localparam logic [1:0] DLY_HI_Z2 = 2'd1;
    localparam logic [1:0] DLY_LO_Z1 = 2'd2;
    localparam logic [1:0] DLY_LO_Z2 = 2'd3;

    // sequencer step of the result for a filtered and a bypassed channel
    localparam logic [3:0] STEP_FINAL     = 4'd14;
    localparam logic [3:0] STEP_FINAL_BYP = 4'd2;

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;
    typedef logic signed [DLY_BITS-1:0]    dly_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;

    typedef enum logic [1:0] {
        OPND_S,
        OPND_X,
        OPND_Y
    } opnd_t;

    typedef enum logic [3:0] {
        CMB_NONE,
        CMB_PAN,
        CMB_YHI,
        CMB_T1,
        CMB_T2,
        CMB_Z1,
        CMB_Z2,
        CMB_YLO,
        CMB_OUT
    } comb_t;

    // one multiply travelling down the MAC pipe
    typedef struct packed {
        comb_t      comb;
        opnd_t      opnd;
        logic [1:0] widx;
        logic       byp;
    } op_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] kidx;
        logic                dly_rd;
        logic [1:0]          ridx;
        comb_t               comb;
        opnd_t               opnd;
        logic [1:0]          widx;
    } ucode_t;

    typedef struct packed {
        logic                 command;
        logic signed [23:0]   sample;
        logic [CH_BITS-1:0]   coef_channel;
        logic [IDX_BITS-1:0]  coef_index;
        logic signed [31:0]   coef_value;
    } in_item_t;

    typedef struct packed {
        logic [CH_BITS-1:0]  channel;
        logic signed [23:0]  sample_out;
        logic                last;
    } out_item_t;

    function automatic ucode_t ucode(input logic [3:0] step);
        ucode_t u;
        u.kidx   = IDX_PAN;
        u.dly_rd = 1'b0;
        u.ridx   = DLY_HI_Z1;
        u.comb   = CMB_NONE;
        u.opnd   = OPND_S;
        u.widx   = DLY_HI_Z1;
        case (step)
            4'd0: begin
                u.kidx = IDX_PAN;     u.opnd = OPND_S; u.comb = CMB_PAN;
            end
            4'd2: begin
                u.kidx = IDX_HI_B0;   u.opnd = OPND_X; u.comb = CMB_YHI;
            end
            4'd3: begin
                u.kidx = IDX_HI_B1;   u.opnd = OPND_X; u.comb = CMB_T1;
                u.dly_rd = 1'b1;      u.ridx = DLY_HI_Z1;
            end
            4'd4: begin
                u.kidx = IDX_HI_B2;   u.opnd = OPND_X; u.comb = CMB_T2;
                u.dly_rd = 1'b1;      u.ridx = DLY_HI_Z2;
            end
            4'd5: begin
                u.kidx = IDX_HI_A1;   u.opnd = OPND_Y; u.comb = CMB_Z1;
                u.widx = DLY_HI_Z1;
            end
            4'd6: begin
                u.kidx = IDX_HI_A2;   u.opnd = OPND_Y; u.comb = CMB_Z2;
                u.widx = DLY_HI_Z2;
            end
            4'd7: begin
                u.kidx = IDX_LO_B0;   u.opnd = OPND_Y; u.comb = CMB_YLO;
            end
            4'd8: begin
                u.kidx = IDX_LO_B1;   u.opnd = OPND_Y; u.comb = CMB_T1;
                u.dly_rd = 1'b1;      u.ridx = DLY_LO_Z1;
            end
            4'd9: begin
                u.kidx = IDX_LO_B2;   u.opnd = OPND_Y; u.comb = CMB_T2;
                u.dly_rd = 1'b1;      u.ridx = DLY_LO_Z2;
            end
            4'd10: begin
                u.kidx = IDX_LO_A1;   u.opnd = OPND_X; u.comb = CMB_Z1;
                u.widx = DLY_LO_Z1;
            end
            4'd11: begin
                u.kidx = IDX_LO_A2;   u.opnd = OPND_X; u.comb = CMB_Z2;
                u.widx = DLY_LO_Z2;
            end
            4'd12: begin
                u.kidx = IDX_OUTGAIN; u.opnd = OPND_X; u.comb = CMB_OUT;
            end
            default: begin
                u.comb = CMB_NONE;
            end
        endcase
        return u;
    endfunction

    function automatic smp_t sat_smp(input acc_t a);
        smp_t r;
        if (&a[ACC_BITS-1:SAMPLE_BITS-1] || ~|a[ACC_BITS-1:SAMPLE_BITS-1]) begin
            r = a[SAMPLE_BITS-1:0];
        end else if (a[ACC_BITS-1]) begin
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic dly_t sat_dly(input acc_t a);
        dly_t r;
        if (&a[ACC_BITS-1:DLY_BITS-1] || ~|a[ACC_BITS-1:DLY_BITS-1]) begin
            r = a[DLY_BITS-1:0];
        end else if (a[ACC_BITS-1]) begin
            r = {1'b1, {(DLY_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(DLY_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### design/mseq_ram.sv
module mseq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 204
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/mseq_ctrl.sv
module mseq_ctrl #(
    parameter int NUM_CHANNELS = 17
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  s_valid,
    output logic                                                  s_ready,
    input  mseq_pkg::in_item_t                                    s_item,
    input  logic                                                  adv,
    output logic                                                  coef_we,
    output logic [$clog2(NUM_CHANNELS*mseq_pkg::WORDS_PER_CH)-1:0] coef_waddr,
    output logic [mseq_pkg::COEF_BITS-1:0]                        coef_wdata,
    output logic [$clog2(NUM_CHANNELS*mseq_pkg::WORDS_PER_CH)-1:0] coef_raddr,
    output logic                                                  dly_re,
    output logic [$clog2(NUM_CHANNELS*mseq_pkg::DLY_PER_CH)-1:0]  dly_raddr,
    output logic [$clog2(NUM_CHANNELS*mseq_pkg::DLY_PER_CH)-1:0]  dly_base,
    output mseq_pkg::op_t                                         iss,
    output mseq_pkg::smp_t                                        sample,
    output logic [mseq_pkg::CH_BITS-1:0]                          ch,
    output logic                                                  last
);

    localparam int NWORD = NUM_CHANNELS * mseq_pkg::WORDS_PER_CH;
    localparam int CW    = $clog2(NWORD);
    localparam int NDLY  = NUM_CHANNELS * mseq_pkg::DLY_PER_CH;
    localparam int DW    = $clog2(NDLY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } st_t;

    st_t                          st_reg, st_next;
    logic [3:0]                   step_reg, step_next;
    logic [mseq_pkg::CH_BITS-1:0] ch_reg, ch_next;
    logic [CW-1:0]                coef_base_reg, coef_base_next;
    logic [DW-1:0]                dly_base_reg, dly_base_next;
    mseq_pkg::smp_t               sample_reg, sample_next;
    logic [NUM_CHANNELS-1:0]      bypass_reg, bypass_next;

    logic                    accept, wr_cmd, ch_ok, byp_we, run, issue_en;
    logic                    byp_cur, at_final, last_ch;
    logic [NUM_CHANNELS-1:0] byp_sh, byp_mask;
    logic [3:0]              final_step;
    mseq_pkg::ucode_t        uc;

    assign s_ready = (st_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign run     = (st_reg == ST_RUN);

    // write items
    assign wr_cmd     = accept && (s_item.command == mseq_pkg::CMD_WRITE);
    assign ch_ok      = {1'b0, s_item.coef_channel} < 6'(NUM_CHANNELS);
    assign coef_we    = wr_cmd && ch_ok &&
                        (s_item.coef_index < mseq_pkg::IDX_BITS'(mseq_pkg::WORDS_PER_CH));
    assign byp_we     = wr_cmd && ch_ok && (s_item.coef_index == mseq_pkg::IDX_BYPASS);
    assign coef_waddr = CW'(9'(s_item.coef_channel) * 9'(mseq_pkg::WORDS_PER_CH)
                            + 9'(s_item.coef_index));
    assign coef_wdata = s_item.coef_value;
    assign byp_mask   = NUM_CHANNELS'(1) << s_item.coef_channel;

    // sequencing
    assign byp_sh     = bypass_reg >> ch_reg;
    assign byp_cur    = byp_sh[0];
    assign uc         = mseq_pkg::ucode(step_reg);
    assign issue_en   = run && (!byp_cur || (step_reg == 4'd0));
    assign final_step = byp_cur ? mseq_pkg::STEP_FINAL_BYP : mseq_pkg::STEP_FINAL;
    assign at_final   = (step_reg == final_step);
    assign last_ch    = (ch_reg == mseq_pkg::CH_BITS'(NUM_CHANNELS - 1));

    always_comb begin
        iss.comb = issue_en ? uc.comb : mseq_pkg::CMB_NONE;
        iss.opnd = uc.opnd;
        iss.widx = uc.widx;
        iss.byp  = byp_cur;
    end

    assign coef_raddr = coef_base_reg + CW'(uc.kidx);
    assign dly_re     = issue_en && uc.dly_rd;
    assign dly_raddr  = dly_base_reg + DW'(uc.ridx);
    assign dly_base   = dly_base_reg;
    assign sample     = sample_reg;
    assign ch         = ch_reg;
    assign last       = last_ch;

    always_comb begin
        st_next        = st_reg;
        step_next      = step_reg;
        ch_next        = ch_reg;
        coef_base_next = coef_base_reg;
        dly_base_next  = dly_base_reg;
        sample_next    = sample_reg;
        bypass_next    = bypass_reg;
        if (byp_we) begin
            if (s_item.coef_value[0]) begin
                bypass_next = bypass_reg | byp_mask;
            end else begin
                bypass_next = bypass_reg & ~byp_mask;
            end
        end
        case (st_reg)
            ST_IDLE: begin
                if (accept && (s_item.command == mseq_pkg::CMD_RENDER)) begin
                    st_next        = ST_RUN;
                    step_next      = '0;
                    ch_next        = '0;
                    coef_base_next = '0;
                    dly_base_next  = '0;
                    sample_next    = s_item.sample;
                end
            end
            ST_RUN: begin
                if (adv) begin
                    if (at_final) begin
                        step_next      = '0;
                        ch_next        = ch_reg + 1'b1;
                        coef_base_next = coef_base_reg + CW'(mseq_pkg::WORDS_PER_CH);
                        dly_base_next  = dly_base_reg + DW'(mseq_pkg::DLY_PER_CH);
                        if (last_ch) begin
                            st_next = ST_IDLE;
                        end
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            step_reg      <= '0;
            ch_reg        <= '0;
            coef_base_reg <= '0;
            dly_base_reg  <= '0;
            bypass_reg    <= '0;
        end else begin
            st_reg        <= st_next;
            step_reg      <= step_next;
            ch_reg        <= ch_next;
            coef_base_reg <= coef_base_next;
            dly_base_reg  <= dly_base_next;
            bypass_reg    <= bypass_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
    end

endmodule

### design/mseq_dp.sv
module mseq_dp #(
    parameter int NUM_CHANNELS   = 17,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 adv,
    input  mseq_pkg::op_t                                        iss,
    input  mseq_pkg::smp_t                                       sample,
    input  logic signed [mseq_pkg::COEF_BITS-1:0]                coef_rdata,
    input  logic                                                 dly_re,
    input  logic [$clog2(NUM_CHANNELS*mseq_pkg::DLY_PER_CH)-1:0] dly_raddr,
    input  logic [$clog2(NUM_CHANNELS*mseq_pkg::DLY_PER_CH)-1:0] dly_base,
    input  logic [mseq_pkg::DLY_BITS-1:0]                        dly_rdata,
    output logic                                                 dly_we,
    output logic [$clog2(NUM_CHANNELS*mseq_pkg::DLY_PER_CH)-1:0] dly_waddr,
    output logic [mseq_pkg::DLY_BITS-1:0]                        dly_wdata,
    output logic                                                 fin,
    output mseq_pkg::smp_t                                       res_sample
);

    localparam int NDLY = NUM_CHANNELS * mseq_pkg::DLY_PER_CH;
    localparam int DW   = $clog2(NDLY);
    localparam int SB   = mseq_pkg::SAMPLE_BITS;
    localparam int CB   = mseq_pkg::COEF_BITS;
    localparam int PW   = mseq_pkg::PROD_BITS;
    localparam int AB   = mseq_pkg::ACC_BITS;
    localparam int DB   = mseq_pkg::DLY_BITS;
    localparam logic [PW:0] HALF = {{(PW - COEF_FRAC_BITS + 1){1'b0}}, 1'b1,
                                    {(COEF_FRAC_BITS - 1){1'b0}}};
    localparam mseq_pkg::op_t OP_IDLE = '{comb: mseq_pkg::CMB_NONE,
                                          opnd: mseq_pkg::OPND_S,
                                          widx: 2'd0, byp: 1'b0};

    mseq_pkg::op_t         iss_reg, cmb_reg;
    logic signed [PW-1:0]  prod_reg, prod_next;
    mseq_pkg::smp_t        x_reg, x_next, y_reg, y_next;
    mseq_pkg::acc_t        t1_reg, t1_next, t2_reg, t2_next;
    logic                  dv_reg;
    logic [NDLY-1:0]       dvalid_reg, dv_sh, dv_mask;

    mseq_pkg::smp_t        opnd;
    logic signed [PW-1:0]  a_ext, b_ext;
    logic signed [PW:0]    rsum, rnd;
    mseq_pkg::acc_t        r_acc, zd_acc, rz_acc;
    mseq_pkg::dly_t        zd;

    // multiply stage: operand against the coefficient word just read
    always_comb begin
        case (iss_reg.opnd)
            mseq_pkg::OPND_S: opnd = sample;
            mseq_pkg::OPND_X: opnd = x_reg;
            mseq_pkg::OPND_Y: opnd = y_reg;
            default:          opnd = sample;
        endcase
        a_ext     = {{CB{opnd[SB-1]}}, opnd};
        b_ext     = {{SB{coef_rdata[CB-1]}}, coef_rdata};
        prod_next = a_ext * b_ext;
    end

    // round half up to the sample LSB
    assign rsum   = {prod_reg[PW-1], prod_reg} + HALF;
    assign rnd    = rsum >>> COEF_FRAC_BITS;
    assign r_acc  = {{(AB - PW - 1){rnd[PW]}}, rnd};
    assign zd     = dv_reg ? dly_rdata : '0;
    assign zd_acc = {{(AB - DB){zd[DB-1]}}, zd};
    assign rz_acc = r_acc + zd_acc;

    assign res_sample = mseq_pkg::sat_smp(r_acc);
    assign fin        = (cmb_reg.comb == mseq_pkg::CMB_OUT) ||
                        ((cmb_reg.comb == mseq_pkg::CMB_PAN) && cmb_reg.byp);

    assign dly_waddr = dly_base + DW'(cmb_reg.widx);
    assign dv_sh     = dvalid_reg >> dly_raddr;
    assign dv_mask   = NDLY'(1) << dly_waddr;

    // combine stage
    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        t1_next   = t1_reg;
        t2_next   = t2_reg;
        dly_we    = 1'b0;
        dly_wdata = mseq_pkg::sat_dly(t1_reg - r_acc);
        case (cmb_reg.comb)
            mseq_pkg::CMB_PAN: x_next  = mseq_pkg::sat_smp(r_acc);
            mseq_pkg::CMB_YHI: y_next  = mseq_pkg::sat_smp(rz_acc);
            mseq_pkg::CMB_T1:  t1_next = rz_acc;
            mseq_pkg::CMB_T2:  t2_next = r_acc;
            mseq_pkg::CMB_Z1: begin
                dly_we    = adv;
                dly_wdata = mseq_pkg::sat_dly(t1_reg - r_acc);
            end
            mseq_pkg::CMB_Z2: begin
                dly_we    = adv;
                dly_wdata = mseq_pkg::sat_dly(t2_reg - r_acc);
            end
            mseq_pkg::CMB_YLO: x_next = mseq_pkg::sat_smp(rz_acc);
            default: begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_reg    <= OP_IDLE;
            cmb_reg    <= OP_IDLE;
            dvalid_reg <= '0;
        end else begin
            if (adv) begin
                iss_reg <= iss;
                cmb_reg <= iss_reg;
            end
            if (dly_we) begin
                dvalid_reg <= dvalid_reg | dv_mask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            if (dly_re) begin
                dv_reg <= dv_sh[0];
            end
        end
    end

endmodule

### design/multichannel_shelf_eq_render_top.sv
// Multichannel shelving equaliser renderer.
// Input channel (s_valid/s_ready/s_item): each item is either a coefficient
// write (command set) or a mono sample to render. A write item gives no
// result; it loads one word of a channel's pan gain, output gain, high- and
// low-shelf biquad coefficients, or its bypass flag.
// A render item gives NUM_CHANNELS result items on m_valid/m_ready/m_item,
// channel 0 first, last set on the highest channel.
// One shared 24x32 MAC walks a schedule of steps for each filtered channel
// (a shorter one for a bypassed channel), reading coefficients and delay
// words from two single-port-read RAMs. A new item is taken only once the
// previous render item has finished.
// Reset clears the bypass flags and marks all delay words as zero; the
// coefficient words hold nothing until written.
// When the receiver stalls, the finished result waits in the output
// register and the sequencer holds on the next channel's final step.
module multichannel_shelf_eq_render_top #(
    parameter int NUM_CHANNELS   = 17,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mseq_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output mseq_pkg::out_item_t m_item
);

    localparam int NWORD = NUM_CHANNELS * mseq_pkg::WORDS_PER_CH;
    localparam int CW    = $clog2(NWORD);
    localparam int NDLY  = NUM_CHANNELS * mseq_pkg::DLY_PER_CH;
    localparam int DW    = $clog2(NDLY);

    logic                          adv, fin, out_load;
    logic                          coef_we, dly_re, dly_we;
    logic [CW-1:0]                 coef_waddr, coef_raddr;
    logic [mseq_pkg::COEF_BITS-1:0] coef_wdata, coef_rdata;
    logic [DW-1:0]                 dly_raddr, dly_waddr, dly_base;
    logic [mseq_pkg::DLY_BITS-1:0] dly_rdata, dly_wdata;
    mseq_pkg::op_t                 iss;
    mseq_pkg::smp_t                sample, res_sample;
    logic [mseq_pkg::CH_BITS-1:0]  ch;
    logic                          last;

    logic                m_valid_reg, m_valid_next;
    mseq_pkg::out_item_t m_item_reg, m_item_next;

    // Hold the whole pipe while a finished result cannot enter the output
    // register.
    assign adv      = !(fin && m_valid_reg && !m_ready);
    assign out_load = fin && adv;

    mseq_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .adv        (adv),
        .coef_we    (coef_we),
        .coef_waddr (coef_waddr),
        .coef_wdata (coef_wdata),
        .coef_raddr (coef_raddr),
        .dly_re     (dly_re),
        .dly_raddr  (dly_raddr),
        .dly_base   (dly_base),
        .iss        (iss),
        .sample     (sample),
        .ch         (ch),
        .last       (last)
    );

    // coefficient words, twelve per channel
    mseq_ram #(
        .WIDTH (mseq_pkg::COEF_BITS),
        .DEPTH (NWORD)
    ) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (coef_we),
        .wr_addr (coef_waddr),
        .wr_data (coef_wdata),
        .rd_en   (adv),
        .rd_addr (coef_raddr),
        .rd_data (coef_rdata)
    );

    // biquad delay words, four per channel
    mseq_ram #(
        .WIDTH (mseq_pkg::DLY_BITS),
        .DEPTH (NDLY)
    ) u_dly_ram (
        .aclk    (aclk),
        .wr_en   (dly_we),
        .wr_addr (dly_waddr),
        .wr_data (dly_wdata),
        .rd_en   (dly_re && adv),
        .rd_addr (dly_raddr),
        .rd_data (dly_rdata)
    );

    mseq_dp #(
        .NUM_CHANNELS   (NUM_CHANNELS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .iss        (iss),
        .sample     (sample),
        .coef_rdata (coef_rdata),
        .dly_re     (dly_re),
        .dly_raddr  (dly_raddr),
        .dly_base   (dly_base),
        .dly_rdata  (dly_rdata),
        .dly_we     (dly_we),
        .dly_waddr  (dly_waddr),
        .dly_wdata  (dly_wdata),
        .fin        (fin),
        .res_sample (res_sample)
    );

    // output register: load a result, drop the flag once the item is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next           = 1'b1;
            m_item_next.channel    = ch;
            m_item_next.sample_out = res_sample;
            m_item_next.last       = last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int NCH  = 17;
    localparam int FRAC = 28;

    localparam logic signed [31:0] UNITY = 32'sh1000_0000;
    // Index codes past the bypass flag: a write to them must be dropped
    localparam logic [mseq_pkg::IDX_BITS-1:0] IDX_SPARE_LO = mseq_pkg::IDX_BYPASS + 4'd1;
    localparam logic [mseq_pkg::IDX_BITS-1:0] IDX_SPARE_HI = 4'hF;

    typedef struct {
        mseq_pkg::in_item_t item;
        bit                 fixed;
        mseq_pkg::smp_t     fixed_val;
    } stim_row_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    mseq_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    mseq_pkg::out_item_t m_item;

    // Shadow of the equaliser: coefficients, delay words, bypass flags
    longint                          coef_mem  [NCH][mseq_pkg::WORDS_PER_CH];
    longint                          delay_mem [NCH][mseq_pkg::DLY_PER_CH];
    bit [NCH-1:0]                    bypassed;
    bit [mseq_pkg::WORDS_PER_CH-1:0] words_set [NCH];

    // Channel results still owed by the block, oldest first
    mseq_pkg::out_item_t pending_outs [$];

    // Typed-in expectation that travels with the item on the input channel
    bit             row_fixed;
    mseq_pkg::smp_t row_fixed_val;

    bit quiet;
    int n_items, n_renders, n_writes, n_dropped, n_filtered, n_results, n_errors;

    multichannel_shelf_eq_render_top #(
        .NUM_CHANNELS   (NCH),
        .COEF_FRAC_BITS (FRAC)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Fixed-point helpers: saturate, and round a Q4.28 product to the
    // sample LSB (round half up)
    // ---------------------------------------------------------------
    function automatic longint clip(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint mac_round(input longint sig, input longint k);
        return (sig * k + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    // One transposed direct form II section; advances that section's delay words
    function automatic longint shelf_stage(input int ch, input bit hi_sec, input longint x);
        int     b0, b1, b2, a1, a2, z1, z2;
        longint y;
        b0 = int'(hi_sec ? mseq_pkg::IDX_HI_B0 : mseq_pkg::IDX_LO_B0);
        b1 = int'(hi_sec ? mseq_pkg::IDX_HI_B1 : mseq_pkg::IDX_LO_B1);
        b2 = int'(hi_sec ? mseq_pkg::IDX_HI_B2 : mseq_pkg::IDX_LO_B2);
        a1 = int'(hi_sec ? mseq_pkg::IDX_HI_A1 : mseq_pkg::IDX_LO_A1);
        a2 = int'(hi_sec ? mseq_pkg::IDX_HI_A2 : mseq_pkg::IDX_LO_A2);
        z1 = int'(hi_sec ? mseq_pkg::DLY_HI_Z1 : mseq_pkg::DLY_LO_Z1);
        z2 = int'(hi_sec ? mseq_pkg::DLY_HI_Z2 : mseq_pkg::DLY_LO_Z2);
        y = clip(mac_round(x, coef_mem[ch][b0]) + delay_mem[ch][z1], mseq_pkg::SAMPLE_BITS);
        delay_mem[ch][z1] = clip(mac_round(x, coef_mem[ch][b1])
                                 - mac_round(y, coef_mem[ch][a1])
                                 + delay_mem[ch][z2], mseq_pkg::DLY_BITS);
        delay_mem[ch][z2] = clip(mac_round(x, coef_mem[ch][b2])
                                 - mac_round(y, coef_mem[ch][a2]), mseq_pkg::DLY_BITS);
        return y;
    endfunction

    // Apply one accepted item to the shadow and queue the channel results it owes
    task automatic eq_apply(input mseq_pkg::in_item_t it, input bit fixed,
                            input mseq_pkg::smp_t fixed_val);
        longint              s, x, y;
        mseq_pkg::out_item_t o;
        if (it.command == mseq_pkg::CMD_WRITE) begin
            n_writes++;
            if (it.coef_channel >= NCH) begin
                n_dropped++;
            end else if (it.coef_index < mseq_pkg::WORDS_PER_CH) begin
                coef_mem[it.coef_channel][it.coef_index]  = longint'(it.coef_value);
                words_set[it.coef_channel][it.coef_index] = 1'b1;
            end else if (it.coef_index == mseq_pkg::IDX_BYPASS) begin
                bypassed[it.coef_channel] = it.coef_value[0];
            end else begin
                n_dropped++;
            end
        end else begin
            n_renders++;
            s = longint'(it.sample);
            for (int ch = 0; ch < NCH; ch++) begin
                x = clip(mac_round(s, coef_mem[ch][mseq_pkg::IDX_PAN]), mseq_pkg::SAMPLE_BITS);
                if (bypassed[ch]) begin
                    y = x;
                end else begin
                    n_filtered++;
                    y = shelf_stage(ch, 1'b1, x);
                    y = shelf_stage(ch, 1'b0, y);
                    y = clip(mac_round(y, coef_mem[ch][mseq_pkg::IDX_OUTGAIN]),
                             mseq_pkg::SAMPLE_BITS);
                end
                o.channel    = 5'(ch);
                o.sample_out = fixed ? fixed_val : mseq_pkg::smp_t'(y);
                o.last       = (ch == NCH - 1);
                pending_outs.push_back(o);
            end
        end
    endtask

    // Predict on every accepted item
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            eq_apply(s_item, row_fixed, row_fixed_val);
        end
    end

    // Check every accepted result against the oldest one owed
    always @(posedge aclk) begin
        mseq_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_outs.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got ch %0d sample %0d last %0b",
                         $time, m_item.channel, m_item.sample_out, m_item.last);
            end else begin
                want = pending_outs.pop_front();
                if (m_item.channel !== want.channel || m_item.sample_out !== want.sample_out
                        || m_item.last !== want.last) begin
                    n_errors++;
                    $display("%0t: mismatch, expected ch %0d sample %0d last %0b,",
                             $time, want.channel, want.sample_out, want.last);
                    $display("    got ch %0d sample %0d last %0b",
                             m_item.channel, m_item.sample_out, m_item.last);
                end
            end
        end
    end

    // Receiver: stall about 8 percent of the time, never during the quiet stretch
    always @(negedge aclk) begin
        m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic mseq_pkg::in_item_t wr_item(input int ch,
                                                   input logic [mseq_pkg::IDX_BITS-1:0] idx,
                                                   input logic signed [31:0] val);
        mseq_pkg::in_item_t it;
        it              = '0;
        it.command      = mseq_pkg::CMD_WRITE;
        it.coef_channel = 5'(ch);
        it.coef_index   = idx;
        it.coef_value   = val;
        return it;
    endfunction

    function automatic stim_row_t wr_row(input int ch, input logic [mseq_pkg::IDX_BITS-1:0] idx,
                                         input logic signed [31:0] val);
        stim_row_t r;
        r.item      = wr_item(ch, idx, val);
        r.fixed     = 1'b0;
        r.fixed_val = '0;
        return r;
    endfunction

    // Render row; with fixed set every channel must give fixed_val
    function automatic stim_row_t rd_row(input logic signed [23:0] smp, input bit fixed,
                                         input mseq_pkg::smp_t fixed_val);
        stim_row_t r;
        r.item         = '0;
        r.item.command = mseq_pkg::CMD_RENDER;
        r.item.sample  = smp;
        r.fixed        = fixed;
        r.fixed_val    = fixed_val;
        return r;
    endfunction

    // Random word in [-r, r]
    function automatic logic signed [31:0] span_word(input longint r);
        return 32'(longint'($urandom_range(0, int'(2 * r))) - r);
    endfunction

    // Pole pair inside the stability triangle
    task automatic stable_poles(output logic signed [31:0] a1, output logic signed [31:0] a2);
        longint one, p1, p2;
        one = longint'(1) <<< FRAC;
        p2  = longint'($urandom_range(0, int'(one * 9 / 10)));
        p1  = longint'($urandom_range(0, int'((one + p2) * 19 / 20)));
        if ($urandom_range(1) == 1) p1 = -p1;
        a1 = 32'(p1);
        a2 = 32'(p2);
    endtask

    // Present one item at a falling edge and hold it until taken; returns at a falling edge
    task automatic push_item(input mseq_pkg::in_item_t it, input bit fixed,
                             input mseq_pkg::smp_t fixed_val);
        while (!quiet && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_item        <= it;
        s_valid       <= 1'b1;
        row_fixed     = fixed;
        row_fixed_val = fixed_val;
        do @(posedge aclk); while (!s_ready);
        n_items++;
        @(negedge aclk);
    endtask

    // Hold the sender until every owed result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_outs.size() != 0) @(negedge aclk);
    endtask

    // Load a whole channel with a sane shelf pair, then set or clear its bypass flag
    task automatic program_channel(input int ch);
        logic signed [31:0] w [mseq_pkg::WORDS_PER_CH];
        logic signed [31:0] flag;
        longint             one;
        one = longint'(1) <<< FRAC;
        w[mseq_pkg::IDX_PAN]     = span_word(one);
        w[mseq_pkg::IDX_OUTGAIN] = span_word(2 * one);
        w[mseq_pkg::IDX_HI_B0]   = span_word(2 * one);
        w[mseq_pkg::IDX_HI_B1]   = span_word(2 * one);
        w[mseq_pkg::IDX_HI_B2]   = span_word(2 * one);
        w[mseq_pkg::IDX_LO_B0]   = span_word(2 * one);
        w[mseq_pkg::IDX_LO_B1]   = span_word(2 * one);
        w[mseq_pkg::IDX_LO_B2]   = span_word(2 * one);
        stable_poles(w[mseq_pkg::IDX_HI_A1], w[mseq_pkg::IDX_HI_A2]);
        stable_poles(w[mseq_pkg::IDX_LO_A1], w[mseq_pkg::IDX_LO_A2]);
        for (int k = 0; k < mseq_pkg::WORDS_PER_CH; k++) begin
            push_item(wr_item(ch, 4'(k), w[k]), 1'b0, '0);
        end
        // mostly enable the filters; upper bits of the flag word are junk
        flag    = $urandom;
        flag[0] = ($urandom_range(99) < 20);
        push_item(wr_item(ch, mseq_pkg::IDX_BYPASS, flag), 1'b0, '0);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        stim_row_t          plan [$];
        mseq_pkg::in_item_t it;
        logic signed [31:0] val;
        int                 ch, pick, decisions, rand_renders;

        quiet = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Unity pan and bypass on every channel so that every render is legal
        for (ch = 0; ch < NCH; ch++) begin
            push_item(wr_item(ch, mseq_pkg::IDX_PAN, UNITY), 1'b0, '0);
            push_item(wr_item(ch, mseq_pkg::IDX_BYPASS, 32'sd1), 1'b0, '0);
        end

        // Directed rows: sample extremes through the bypass path, dropped writes,
        // gain extremes, then channel 0 taken through both shelves
        plan.push_back(rd_row(24'sd0, 1'b1, 24'sd0));
        plan.push_back(rd_row(24'sh7FFFFF, 1'b1, 24'sh7FFFFF));
        plan.push_back(rd_row(24'sh800000, 1'b1, 24'sh800000));
        plan.push_back(wr_row(NCH, mseq_pkg::IDX_PAN, 32'sd0));
        plan.push_back(wr_row(31, mseq_pkg::IDX_BYPASS, 32'sd0));
        plan.push_back(wr_row(0, IDX_SPARE_LO, 32'sh7FFF_FFFF));
        plan.push_back(wr_row(0, IDX_SPARE_HI, -32'sd1));
        plan.push_back(rd_row(-24'sd1, 1'b1, -24'sd1));
        plan.push_back(wr_row(16, mseq_pkg::IDX_PAN, 32'sh7FFF_FFFF));
        plan.push_back(wr_row(3, mseq_pkg::IDX_PAN, 32'sh8000_0000));
        plan.push_back(rd_row(24'sh7FFFFF, 1'b0, '0));
        plan.push_back(rd_row(24'sh800000, 1'b0, '0));
        plan.push_back(wr_row(0, mseq_pkg::IDX_OUTGAIN, 32'sh0C00_0000));
        plan.push_back(wr_row(0, mseq_pkg::IDX_HI_B0, 32'sh1200_0000));
        plan.push_back(wr_row(0, mseq_pkg::IDX_HI_B1, 32'shE400_0000));
        plan.push_back(wr_row(0, mseq_pkg::IDX_HI_B2, 32'sh0B00_0000));
        plan.push_back(wr_row(0, mseq_pkg::IDX_HI_A1, 32'shE600_0000));
        plan.push_back(wr_row(0, mseq_pkg::IDX_HI_A2, 32'sh0A80_0000));
        plan.push_back(wr_row(0, mseq_pkg::IDX_LO_B0, 32'sh1040_0000));
        plan.push_back(wr_row(0, mseq_pkg::IDX_LO_B1, 32'shE200_0000));
        plan.push_back(wr_row(0, mseq_pkg::IDX_LO_B2, 32'sh0E00_0000));
        plan.push_back(wr_row(0, mseq_pkg::IDX_LO_A1, 32'shE280_0000));
        plan.push_back(wr_row(0, mseq_pkg::IDX_LO_A2, 32'sh0E40_0000));
        // clear the flag: only bit 0 of the word counts
        plan.push_back(wr_row(0, mseq_pkg::IDX_BYPASS, 32'shFFFF_FFFE));
        plan.push_back(rd_row(24'sh400000, 1'b0, '0));
        plan.push_back(rd_row(-24'sd3000000, 1'b0, '0));
        foreach (plan[r]) begin
            push_item(plan[r].item, plan[r].fixed, plan[r].fixed_val);
        end

        // Let the block run dry before the random part
        wait_drained();

        decisions    = 0;
        rand_renders = 0;
        while (n_items < 125 || rand_renders < 18) begin
            quiet = (decisions >= 12 && decisions < 32);
            pick  = $urandom_range(99);
            it    = '0;
            if (pick < 55) begin
                // render with junk in the unused fields
                it.command      = mseq_pkg::CMD_RENDER;
                it.coef_channel = 5'($urandom);
                it.coef_index   = 4'($urandom);
                it.coef_value   = $urandom;
                case ($urandom_range(9))
                    0:       it.sample = 24'sh7FFFFF;
                    1:       it.sample = 24'sh800000;
                    2:       it.sample = 24'($urandom_range(0, 255)) - 24'd128;
                    default: it.sample = 24'($urandom);
                endcase
                push_item(it, 1'b0, '0);
                rand_renders++;
            end else if (pick < 63) begin
                program_channel($urandom_range(NCH - 1));
            end else if (pick < 83) begin
                // single word: sane gain most of the time, any 32-bit word otherwise
                ch  = $urandom_range(NCH - 1);
                val = ($urandom_range(3) == 0) ? 32'($urandom)
                                               : span_word(longint'(2) <<< FRAC);
                it  = wr_item(ch, 4'($urandom_range(mseq_pkg::WORDS_PER_CH - 1)), val);
                it.sample = 24'($urandom);
                push_item(it, 1'b0, '0);
            end else if (pick < 90) begin
                // bypass toggle; keep bypass on where the channel is not fully loaded
                ch  = $urandom_range(NCH - 1);
                val = $urandom;
                if (!(&words_set[ch])) val[0] = 1'b1;
                push_item(wr_item(ch, mseq_pkg::IDX_BYPASS, val), 1'b0, '0);
            end else if (pick < 95) begin
                // channel out of range: drop
                it = wr_item($urandom_range(31, NCH), 4'($urandom), $urandom);
                it.sample = 24'($urandom);
                push_item(it, 1'b0, '0);
            end else if (pick < 98) begin
                // spare index: drop
                it = wr_item($urandom_range(NCH - 1),
                             4'($urandom_range(IDX_SPARE_HI, IDX_SPARE_LO)), $urandom);
                push_item(it, 1'b0, '0);
            end else begin
                wait_drained();
            end
            decisions++;
        end
        quiet   = 1'b0;
        s_valid <= 1'b0;

        wait_drained();
        repeat (40) @(negedge aclk);

        $display("Covered %0d items: %0d renders, %0d coefficient writes (%0d dropped),",
                 n_items, n_renders, n_writes, n_dropped);
        $display("%0d channel results checked, %0d of them through both shelves.",
                 n_results, n_filtered);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
